[sv/iirdf_pkg.sv]
// ----------------------------------------------------------------------------
// iirdf_pkg
// Shared widths, codes and helpers of the IIR position controller.
// ----------------------------------------------------------------------------
package iirdf_pkg;

    localparam int MAX_ORDER_DEF = 10;

    // Coefficient, multiplier operand, digit, product and delay widths
    localparam int COEF_W  = 32;
    localparam int MPL_W   = 28;
    localparam int DIGIT_W = 4;
    localparam int N_DIGIT = MPL_W / DIGIT_W;
    localparam int PP_W    = COEF_W + DIGIT_W + 1;
    localparam int PROD_W  = 60;
    localparam int DLY_W   = 48;

    // Item function codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_WR_B   = 2'd1;
    localparam logic [1:0] FUNC_WR_A   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ORDER   = 3'd0;
    localparam logic [2:0] CFG_OFFSET  = 3'd1;
    localparam logic [2:0] CFG_PFLOOR  = 3'd2;
    localparam logic [2:0] CFG_PCEIL   = 3'd3;
    localparam logic [2:0] CFG_RFLOOR  = 3'd4;
    localparam logic [2:0] CFG_RCEIL   = 3'd5;

    // Saturate a wide sum to a signed delay word
    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [PROD_W-1:0] v);
        logic signed [DLY_W-1:0] res;
        if (v > $signed({{(PROD_W-DLY_W+1){1'b0}}, {(DLY_W-1){1'b1}}})) begin
            res = {1'b0, {(DLY_W-1){1'b1}}};
        end else if (v < $signed({{(PROD_W-DLY_W+1){1'b1}}, {(DLY_W-1){1'b0}}})) begin
            res = {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            res = v[DLY_W-1:0];
        end
        return res;
    endfunction

endpackage

[sv/iir_df2t_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// iir_df2t_controller_antiwindup
// Transposed direct-form-II IIR position controller with anti-windup freeze.
// ----------------------------------------------------------------------------
// A control sample first runs the b0 product that sets the output; then two
// digit-serial multipliers run b[i]*e and a[i]*yfb side by side for each tap.
// Coefficient writes with an index up to MAX_ORDER clear the delay words.
// One item is worked on at a time; a finished result waits in the output
// register.
module iir_df2t_controller_antiwindup #(
    parameter int MAX_ORDER = iirdf_pkg::MAX_ORDER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [3:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    input  logic signed [15:0] i_position,
    input  logic signed [15:0] i_reference,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [16:0] o_delta_command,
    output logic [15:0]        o_pwm_value,
    output logic               o_sat_high,
    output logic               o_sat_low,
    output logic               o_state_frozen,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int OW  = $clog2(MAX_ORDER + 1);
    localparam int DAW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int PW  = iirdf_pkg::PROD_W;
    localparam int DW  = iirdf_pkg::DLY_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_B0   = 3'd1;
    localparam logic [2:0] ST_TAP  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;

    // Configuration
    logic [3:0]         r_cfg_order;
    logic [15:0]        r_offset;
    logic [15:0]        r_pfloor;
    logic [15:0]        r_pceil;
    logic signed [15:0] r_rfloor;
    logic signed [15:0] r_rceil;

    // Coefficients and delay words
    logic signed [31:0]   r_b  [MAX_ORDER+1];
    logic signed [31:0]   r_a  [MAX_ORDER+1];
    logic signed [DW-1:0] r_w  [MAX_ORDER];
    logic signed [DW-1:0] r_wn [MAX_ORDER];

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [OW-1:0]        r_ord;
    logic [OW-1:0]        r_tap;
    logic signed [16:0]   r_e;
    logic signed [DW-1:0] r_acc;
    logic signed [24:0]   r_yfb;

    logic               r_out_valid;
    logic signed [16:0] r_cmd;
    logic [15:0]        r_pwm;
    logic               r_hi;
    logic               r_lo;
    logic               r_frz;

    // Datapath nets
    logic                 accept;
    logic                 is_sample;
    logic                 is_write;
    logic                 idx_ok;
    logic signed [15:0]   ref_c;
    logic signed [16:0]   n_e;
    logic [OW-1:0]        n_ord;
    logic                 start_b;
    logic                 start_a;
    logic [OW-1:0]        coef_sel;
    logic signed [27:0]   plier_b;
    logic signed [27:0]   plier_a;
    logic                 done_b;
    logic                 done_a;
    logic signed [PW-1:0] prod_b;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] acc_sum;
    logic signed [DW-1:0] n_acc;
    logic signed [DW:0]   yfb_t;
    logic signed [24:0]   n_yfb;
    logic signed [DW-1:0] w_next;
    logic signed [PW-1:0] tap_sum;
    logic                 fin_go;
    logic signed [DW:0]   u_t;
    logic signed [20:0]   u;
    logic signed [20:0]   umin;
    logic signed [20:0]   umax;
    logic                 n_hi;
    logic                 n_lo;
    logic                 n_frz;
    logic signed [20:0]   cmd_w;
    logic signed [20:0]   pwm_t;
    logic signed [20:0]   pwm_w;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign is_sample   = (i_func == iirdf_pkg::FUNC_SAMPLE);
    assign is_write    = (i_func == iirdf_pkg::FUNC_WR_B) || (i_func == iirdf_pkg::FUNC_WR_A);
    assign idx_ok      = (32'(i_coef_index) <= MAX_ORDER);

    // Clamp reference, form error and effective order
    always_comb begin
        if (i_reference > r_rceil) begin
            ref_c = r_rceil;
        end else if (i_reference < r_rfloor) begin
            ref_c = r_rfloor;
        end else begin
            ref_c = i_reference;
        end
        n_e   = 17'(ref_c) - 17'(i_position);
        n_ord = (32'(r_cfg_order) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(r_cfg_order);
    end

    // Output sum, feedback value and next delay word
    always_comb begin
        acc_sum = prod_b;
        if (r_ord != '0) begin
            acc_sum = prod_b + PW'(r_w[0]);
        end
        n_acc = iirdf_pkg::sat_dly(acc_sum);
        yfb_t = (DW+1)'(n_acc) + (DW+1)'(1 <<< 23);
        n_yfb = yfb_t[DW:24];
        w_next = '0;
        if (r_tap < r_ord) begin
            w_next = r_w[DAW'(r_tap)];
        end
        tap_sum = PW'(w_next) + prod_b - prod_a;
    end

    // Multiplier launch
    always_comb begin
        start_b  = 1'b0;
        start_a  = 1'b0;
        coef_sel = '0;
        plier_b  = 28'(r_e);
        plier_a  = 28'(r_yfb);
        if (accept && is_sample) begin
            start_b = 1'b1;
            plier_b = 28'(n_e);
        end else if (r_state == ST_B0 && done_b && r_ord != '0) begin
            start_b  = 1'b1;
            start_a  = 1'b1;
            coef_sel = OW'(1);
            plier_a  = 28'(n_yfb);
        end else if (r_state == ST_TAP && done_b && r_tap != r_ord) begin
            start_b  = 1'b1;
            start_a  = 1'b1;
            coef_sel = r_tap + 1'b1;
        end
    end

    iirdf_mul u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_b),
        .i_cand  (r_b[coef_sel]),
        .i_plier (plier_b),
        .o_done  (done_b),
        .o_prod  (prod_b)
    );

    iirdf_mul u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_a),
        .i_cand  (r_a[coef_sel]),
        .i_plier (plier_a),
        .o_done  (done_a),
        .o_prod  (prod_a)
    );

    // Command rounding, saturation and freeze decision
    always_comb begin
        u_t   = (DW+1)'(r_acc) + (DW+1)'(1 <<< 27);
        u     = u_t[DW:28];
        umin  = 21'({5'd0, r_pfloor}) - 21'({5'd0, r_offset});
        umax  = 21'({5'd0, r_pceil}) - 21'({5'd0, r_offset});
        n_hi  = (u > umax);
        n_lo  = (u < umin);
        if (n_hi) begin
            cmd_w = umax;
        end else if (n_lo) begin
            cmd_w = umin;
        end else begin
            cmd_w = u;
        end
        n_frz = (n_hi && r_e > 0) || (n_lo && r_e < 0);
        pwm_t = cmd_w + 21'({5'd0, r_offset});
        if (pwm_t > 21'({5'd0, r_pceil})) begin
            pwm_w = 21'({5'd0, r_pceil});
        end else if (pwm_t < 21'({5'd0, r_pfloor})) begin
            pwm_w = 21'({5'd0, r_pfloor});
        end else begin
            pwm_w = pwm_t;
        end
    end

    assign fin_go = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);

    // Sequence control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_sample) begin
                    n_state = ST_B0;
                end
            end
            ST_B0: begin
                if (done_b) begin
                    n_state = (r_ord == '0) ? ST_FIN : ST_TAP;
                end
            end
            ST_TAP: begin
                if (done_b && r_tap == r_ord) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_B0 && done_b) begin
                r_tap <= OW'(1);
            end else if (r_state == ST_TAP && done_b && r_tap != r_ord) begin
                r_tap <= r_tap + 1'b1;
            end
        end
    end

    // Hold sample context
    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            r_e   <= n_e;
            r_ord <= n_ord;
        end
        if (r_state == ST_B0 && done_b) begin
            r_acc <= n_acc;
            r_yfb <= n_yfb;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_order <= '0;
            r_offset    <= '0;
            r_pfloor    <= '0;
            r_pceil     <= 16'hFFFF;
            r_rfloor    <= 16'sh8000;
            r_rceil     <= 16'sh7FFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                iirdf_pkg::CFG_ORDER:  r_cfg_order <= i_cfg_data[3:0];
                iirdf_pkg::CFG_OFFSET: r_offset    <= i_cfg_data;
                iirdf_pkg::CFG_PFLOOR: r_pfloor    <= i_cfg_data;
                iirdf_pkg::CFG_PCEIL:  r_pceil     <= i_cfg_data;
                iirdf_pkg::CFG_RFLOOR: r_rfloor    <= i_cfg_data;
                iirdf_pkg::CFG_RCEIL:  r_rceil     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAX_ORDER; k++) begin
                r_b[k] <= '0;
                r_a[k] <= '0;
            end
        end else if (accept && is_write && idx_ok) begin
            if (i_func == iirdf_pkg::FUNC_WR_B) begin
                r_b[OW'(i_coef_index)] <= i_coef_value;
            end else begin
                r_a[OW'(i_coef_index)] <= i_coef_value;
            end
        end
    end

    // Delay words: cleared on coefficient writes; next set built aside, committed unless frozen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_w[k] <= '0;
            end
        end else if (accept && is_write && idx_ok) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_w[k] <= '0;
            end
        end else if (fin_go && r_ord != '0 && !n_frz) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_w[k] <= r_wn[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_wn[k] <= r_w[k];
            end
        end else if (r_state == ST_TAP && done_b) begin
            r_wn[DAW'(r_tap - 1'b1)] <= iirdf_pkg::sat_dly(tap_sum);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_cmd <= cmd_w[16:0];
            r_pwm <= pwm_w[15:0];
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_frz <= n_frz;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_delta_command = r_cmd;
    assign o_pwm_value     = r_pwm;
    assign o_sat_high      = r_hi;
    assign o_sat_low       = r_lo;
    assign o_state_frozen  = r_frz;

    // Checks
    a_mul_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAP && done_b) |-> done_a)
        else $error("tap multipliers out of step");

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAP) |-> (r_tap != '0 && r_tap <= r_ord))
        else $error("tap counter out of range");

    a_frz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_state_frozen |-> (o_sat_high || o_sat_low))
        else $error("freeze without saturation");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_sample) |=> o_in_stall)
        else $error("sample accepted without holding input");

endmodule

[sv/iirdf_mul.sv]
// ----------------------------------------------------------------------------
// iirdf_mul
// Digit-serial signed multiplier: one 4-bit digit of the multiplier per cycle,
// most significant digit first.
// ----------------------------------------------------------------------------
module iirdf_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [iirdf_pkg::COEF_W-1:0]   i_cand,
    input  logic signed [iirdf_pkg::MPL_W-1:0]    i_plier,
    output logic                                  o_done,
    output logic signed [iirdf_pkg::PROD_W-1:0]   o_prod
);

    localparam int CNT_W = $clog2(iirdf_pkg::N_DIGIT);

    logic                                   r_busy;
    logic                                   r_done;
    logic [CNT_W-1:0]                       r_cnt;
    logic signed [iirdf_pkg::COEF_W-1:0]    r_cand;
    logic [iirdf_pkg::MPL_W-1:0]            r_plier;
    logic signed [iirdf_pkg::PROD_W-1:0]    r_acc;

    logic [iirdf_pkg::DIGIT_W-1:0]          digit;
    logic signed [iirdf_pkg::DIGIT_W:0]     sdigit;
    logic signed [iirdf_pkg::PP_W-1:0]      pp;
    logic signed [iirdf_pkg::PROD_W-1:0]    n_acc;

    // Top digit is signed, the rest unsigned
    always_comb begin
        digit  = r_plier[iirdf_pkg::MPL_W-1 -: iirdf_pkg::DIGIT_W];
        sdigit = (r_cnt == '0) ? {digit[iirdf_pkg::DIGIT_W-1], digit} : {1'b0, digit};
        pp     = r_cand * sdigit;
        n_acc  = (r_acc <<< iirdf_pkg::DIGIT_W)
               + {{(iirdf_pkg::PROD_W-iirdf_pkg::PP_W){pp[iirdf_pkg::PP_W-1]}}, pp};
    end

    // Advance one digit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(iirdf_pkg::N_DIGIT - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cand  <= i_cand;
            r_plier <= i_plier;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_plier <= r_plier << iirdf_pkg::DIGIT_W;
            r_acc   <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
